[rtl/core/rc6_pkg.sv]
// ----------------------------------------------------------------------------
// RC6 package
// Shared types, constants and word functions for the RC6-32 cipher block.
// ----------------------------------------------------------------------------
package rc6_pkg;

  localparam int ROUNDS      = 20;
  localparam int NUM_SK      = 2 * ROUNDS + 4;
  localparam int KEY_WORDS   = 8;
  localparam int NUM_KEY_REGS = 4;
  localparam int EXP_STEPS   = 3 * ((NUM_SK > KEY_WORDS) ? NUM_SK : KEY_WORDS);
  localparam int LAST_STAGE  = ROUNDS + 1;

  localparam int SK_AW  = $clog2(NUM_SK);
  localparam int STG_W  = $clog2(LAST_STAGE + 1);
  localparam int EXP_W  = $clog2(EXP_STEPS);
  localparam int KW_AW  = $clog2(KEY_WORDS);
  localparam int REG_AW = $clog2(NUM_KEY_REGS);

  localparam logic [31:0] P32 = 32'hB7E15163;
  localparam logic [31:0] Q32 = 32'h9E3779B9;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_a;
    logic [31:0] result_b;
    logic [31:0] result_c;
    logic [31:0] result_d;
  } out_word_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } blk_t;

  // Which step of the cipher the datapath performs this cycle.
  typedef struct packed {
    logic dec;
    logic first;
    logic last;
  } stage_ctl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

  function automatic logic [31:0] mix_f(input logic [31:0] x);
    logic [31:0] p;
    p = x * ({x[30:0], 1'b0} + 32'd1);
    return rotl32(p, 5'd5);
  endfunction

endpackage

[rtl/core/rc6_round.sv]
// ----------------------------------------------------------------------------
// RC6 round datapath
// One cipher step per cycle: whitening, a full round, or final whitening,
// in either direction, using one pair of round keys.
// ----------------------------------------------------------------------------
module rc6_round (
  input  rc6_pkg::blk_t       blk_in,
  input  logic [31:0]         k0,
  input  logic [31:0]         k1,
  input  rc6_pkg::stage_ctl_t ctl,
  output rc6_pkg::blk_t       blk_out
);
  import rc6_pkg::*;

  logic [31:0] t, u, ea, ec, da, dc;

  // Both multipliers work on the word pair that feeds the round in either direction.
  always_comb begin
    if (ctl.dec) begin
      t = mix_f(blk_in.a);
      u = mix_f(blk_in.c);
    end else begin
      t = mix_f(blk_in.b);
      u = mix_f(blk_in.d);
    end
    ea = rotl32(blk_in.a ^ t, u[4:0]) + k0;
    ec = rotl32(blk_in.c ^ u, t[4:0]) + k1;
    dc = rotr32(blk_in.b - k1, t[4:0]) ^ u;
    da = rotr32(blk_in.d - k0, u[4:0]) ^ t;
  end

  always_comb begin
    blk_out = blk_in;
    if (!ctl.dec) begin
      if (ctl.first) begin
        blk_out.b = blk_in.b + k0;
        blk_out.d = blk_in.d + k1;
      end else if (ctl.last) begin
        blk_out.a = blk_in.a + k0;
        blk_out.c = blk_in.c + k1;
      end else begin
        blk_out = '{a: blk_in.b, b: ec, c: blk_in.d, d: ea};
      end
    end else begin
      if (ctl.first) begin
        blk_out.a = blk_in.a - k0;
        blk_out.c = blk_in.c - k1;
      end else if (ctl.last) begin
        blk_out.b = blk_in.b - k0;
        blk_out.d = blk_in.d - k1;
      end else begin
        blk_out = '{a: da, b: blk_in.a, c: dc, d: blk_in.c};
      end
    end
  end

endmodule

[rtl/core/rc6_block_cipher.sv]
// ----------------------------------------------------------------------------
// RC6-32/20 block cipher with a 256-bit key
// Encrypts or decrypts one 128-bit block per input word, round keys in RAM.
// ----------------------------------------------------------------------------
// Usage. The user writes the key through the cfg_ port as four 64-bit registers,
// only while the block is idle; the block does not enforce this. Each write
// marks the round key schedule stale. An input word carries a request type
// (encrypt or decrypt) and four block words; it is taken when in_valid and
// in_ready are both high, and in_ready is high only while no block is in
// progress. The result word appears on out_data with out_valid and is held
// until out_ready is seen high. After acceptance, a block fetches its first
// key pair in the load state, then runs through the single round unit:
// initial whitening, twenty rounds, final whitening, one round per cycle as
// the round unit and the two-port key RAM allow. The next word is taken only
// in the idle state after the result. The first block after reset or after
// a key write first runs the key expansion, 132 mixing steps at one step per
// cycle.
// Reset clears the key registers to zero and the schedule as stale; the key
// RAM itself is not cleared, since expansion always writes it before use.
// When the receiver stalls, the finished result stays in the output register
// and the next block may still be accepted; it then waits at its last step.
// ----------------------------------------------------------------------------
module rc6_block_cipher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rc6_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rc6_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [63:0]        cfg_wdata
);
  import rc6_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXP  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  // Key registers and schedule status.
  logic [63:0] key_r [NUM_KEY_REGS];
  logic        sched_valid_r;

  logic [1:0]  state_r;
  logic        dec_r;
  blk_t        blk_r;
  logic [STG_W-1:0] stage_r;

  // Key expansion state.
  logic [EXP_W-1:0] step_r;
  logic [SK_AW-1:0] ei_r;
  logic [KW_AW-1:0] ej_r;
  logic [31:0]      ea_r, eb_r, init_r;
  logic [31:0]      lw_r [KEY_WORDS];

  // Round key RAM: one write port, two registered read ports.
  logic [31:0]      sk_mem [NUM_SK];
  logic [31:0]      rd_a_r, rd_b_r;
  logic [SK_AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic [31:0]      wr_data;
  logic             wr_en;

  out_word_t out_r;
  logic      out_valid_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sk_mem[wr_addr] <= wr_data;
    end
    rd_a_r <= sk_mem[rd_addr_a];
    rd_b_r <= sk_mem[rd_addr_b];
  end

  // Expansion step: the first pass takes the initial P/Q sequence directly.
  logic [31:0] s_val, na, nb_sum, nab, nb;
  always_comb begin
    s_val  = (step_r < EXP_W'(NUM_SK)) ? init_r : rd_a_r;
    na     = rotl32(s_val + ea_r + eb_r, 5'd3);
    nab    = na + eb_r;
    nb_sum = lw_r[ej_r] + nab;
    nb     = rotl32(nb_sum, nab[4:0]);
  end

  // Key pair addressing for the step that runs next cycle; during expansion, the RAM write and read addresses.
  logic [STG_W-1:0] nstage, pair;
  always_comb begin
    if (state_r == ST_RUN && stage_r != STG_W'(LAST_STAGE)) begin
      nstage = stage_r + 1'b1;
    end else if (state_r == ST_RUN) begin
      nstage = stage_r;
    end else begin
      nstage = '0;
    end
    pair = dec_r ? (STG_W'(LAST_STAGE) - nstage) : nstage;
    wr_en   = (state_r == ST_EXP);
    wr_addr = ei_r;
    wr_data = na;
    if (state_r == ST_EXP) begin
      rd_addr_a = (ei_r == SK_AW'(NUM_SK - 1)) ? '0 : ei_r + 1'b1;
      rd_addr_b = rd_addr_a;
    end else begin
      rd_addr_a = SK_AW'({pair, 1'b0});
      rd_addr_b = SK_AW'({pair, 1'b1});
    end
  end

  stage_ctl_t ctl;
  blk_t       blk_nxt;
  assign ctl = '{dec: dec_r, first: (stage_r == '0),
                 last: (stage_r == STG_W'(LAST_STAGE))};

  rc6_round u_round (
    .blk_in (blk_r),
    .k0     (rd_a_r),
    .k1     (rd_b_r),
    .ctl    (ctl),
    .blk_out(blk_nxt)
  );

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // A finished block enters the output register this cycle.
  logic out_load;
  assign out_load = (state_r == ST_RUN) && (stage_r == STG_W'(LAST_STAGE)) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      sched_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int k = 0; k < NUM_KEY_REGS; k++) begin
        key_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        key_r[cfg_idx] <= cfg_wdata;
        sched_valid_r  <= 1'b0;
      end
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            dec_r <= in_data.req_type;
            blk_r <= '{a: in_data.word_a, b: in_data.word_b,
                       c: in_data.word_c, d: in_data.word_d};
            stage_r <= '0;
            if (sched_valid_r) begin
              state_r <= ST_LOAD;
            end else begin
              state_r <= ST_EXP;
              step_r  <= '0;
              ei_r    <= '0;
              ej_r    <= '0;
              ea_r    <= '0;
              eb_r    <= '0;
              init_r  <= P32;
              for (int k = 0; k < NUM_KEY_REGS; k++) begin
                lw_r[2*k]   <= key_r[k][31:0];
                lw_r[2*k+1] <= key_r[k][63:32];
              end
            end
          end
        end
        ST_EXP: begin
          ea_r       <= na;
          eb_r       <= nb;
          lw_r[ej_r] <= nb;
          init_r     <= init_r + Q32;
          ei_r       <= (ei_r == SK_AW'(NUM_SK - 1)) ? '0 : ei_r + 1'b1;
          ej_r       <= ej_r + 1'b1;
          step_r     <= step_r + 1'b1;
          if (step_r == EXP_W'(EXP_STEPS - 1)) begin
            sched_valid_r <= 1'b1;
            state_r       <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (stage_r != STG_W'(LAST_STAGE)) begin
            blk_r   <= blk_nxt;
            stage_r <= stage_r + 1'b1;
          end else if (out_free) begin
            out_r <= '{result_a: blk_nxt.a, result_b: blk_nxt.b,
                       result_c: blk_nxt.c, result_d: blk_nxt.d};
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
